### rtl/depth_pixel_back_projection_defines.svh
// ----------------------------------------------------------------------------
// Depth pixel back-projection assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef DEPTH_PIXEL_BACK_PROJECTION_DEFINES_SVH
`define DEPTH_PIXEL_BACK_PROJECTION_DEFINES_SVH

// overlapping implication, sampled on clock, off during reset
`define DPBP_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define DPBP_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/dpbp_pkg.sv
// ----------------------------------------------------------------------------
// Depth pixel back-projection package
// Widths, register codes, reset values and shared helpers.
// ----------------------------------------------------------------------------
package dpbp_pkg;

   localparam int COORD_BITS_DEF = 12;

   localparam int PIX_W      = 8;
   localparam int COORD_IN_W = 12;
   localparam int CENTER_W   = 20;
   localparam int INV_W      = 24;
   localparam int SCALE_W    = 16;
   localparam int THRESH_W   = 8;
   localparam int Z_W        = 24;
   localparam int POINT_W    = 32;
   localparam int POINT_Z_W  = 31;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int SPLIT_W    = 24;
   localparam int DROP_W     = 32;
   localparam int BACK_DEPTH = 4;

   localparam logic [PIX_W-1:0]   PIX_FAR  = 8'hFF;
   localparam logic [POINT_W-1:0] SAT_POS  = 32'h7FFF_FFFF;
   localparam logic [POINT_W-1:0] SAT_NEG  = 32'h8000_0000;
   localparam logic [63:0]        ROUND_HALF = 64'h0000_0000_8000_0000;
   localparam logic [63:0]        LIM_POS    = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0]        LIM_NEG    = 64'h0000_0000_8000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X    = 3'd0,
      CSR_CENTER_Y    = 3'd1,
      CSR_INV_FOCAL_X = 3'd2,
      CSR_INV_FOCAL_Y = 3'd3,
      CSR_DEPTH_SCALE = 3'd4,
      CSR_INVALID_THR = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [CENTER_W-1:0] center_x;
      logic [CENTER_W-1:0] center_y;
      logic [INV_W-1:0]    inv_focal_x;
      logic [INV_W-1:0]    inv_focal_y;
      logic [SCALE_W-1:0]  depth_scale;
      logic [THRESH_W-1:0] invalid_threshold;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      center_x:          20'd83365,
      center_y:          20'd61102,
      inv_focal_x:       24'd32070,
      inv_focal_y:       24'd32070,
      depth_scale:       16'd19624,
      invalid_threshold: 8'd254
   };

   // magnitude width of (coordinate.8 - center)
   function automatic int mag_width(input int cb);
      return ((cb + 8) > CENTER_W) ? (cb + 8) : CENTER_W;
   endfunction

endpackage

### rtl/dpbp_csr.sv
// ----------------------------------------------------------------------------
// Depth pixel back-projection configuration registers
// Holds the camera intrinsics, depth scale and invalid threshold.
// ----------------------------------------------------------------------------
module dpbp_csr (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write,
   input  logic [dpbp_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [dpbp_pkg::CSR_DATA_W-1:0]         csr_wdata,
   output dpbp_pkg::cfg_type                       cfg
);

   dpbp_pkg::cfg_type cfg_ff;
   dpbp_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (dpbp_pkg::csr_idx_type'(csr_index))
            dpbp_pkg::CSR_CENTER_X: begin
               cfg_in.center_x = csr_wdata[dpbp_pkg::CENTER_W-1:0];
            end
            dpbp_pkg::CSR_CENTER_Y: begin
               cfg_in.center_y = csr_wdata[dpbp_pkg::CENTER_W-1:0];
            end
            dpbp_pkg::CSR_INV_FOCAL_X: begin
               cfg_in.inv_focal_x = csr_wdata[dpbp_pkg::INV_W-1:0];
            end
            dpbp_pkg::CSR_INV_FOCAL_Y: begin
               cfg_in.inv_focal_y = csr_wdata[dpbp_pkg::INV_W-1:0];
            end
            dpbp_pkg::CSR_DEPTH_SCALE: begin
               cfg_in.depth_scale = csr_wdata[dpbp_pkg::SCALE_W-1:0];
            end
            dpbp_pkg::CSR_INVALID_THR: begin
               cfg_in.invalid_threshold = csr_wdata[dpbp_pkg::THRESH_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= dpbp_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/dpbp_front.sv
// ----------------------------------------------------------------------------
// Depth pixel back-projection front end
// Two stages: threshold, inverted depth and signed offsets; then depth z.
// ----------------------------------------------------------------------------
module dpbp_front #(
   parameter int COORD_BITS = dpbp_pkg::COORD_BITS_DEF,
   localparam int MAG_W = dpbp_pkg::mag_width(COORD_BITS)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dpbp_pkg::cfg_type                    cfg,
   input  logic                                 in_valid,
   input  logic [dpbp_pkg::PIX_W-1:0]           pixel_value,
   input  logic [dpbp_pkg::COORD_IN_W-1:0]      pixel_column,
   input  logic [dpbp_pkg::COORD_IN_W-1:0]      pixel_row,
   output logic                                 out_valid,
   output logic [dpbp_pkg::Z_W-1:0]             out_z,
   output logic                                 out_neg_x,
   output logic [MAG_W-1:0]                     out_mag_x,
   output logic                                 out_neg_y,
   output logic [MAG_W-1:0]                     out_mag_y
);

   localparam int DIFF_W = MAG_W + 1;
   localparam int CW = (COORD_BITS < dpbp_pkg::COORD_IN_W) ? COORD_BITS
                                                          : dpbp_pkg::COORD_IN_W;

   logic                         vld1_ff, vld1_in;
   logic [dpbp_pkg::PIX_W-1:0]   d1_ff, d1_in;
   logic                         neg_x1_ff, neg_x1_in, neg_y1_ff, neg_y1_in;
   logic [MAG_W-1:0]             mag_x1_ff, mag_x1_in, mag_y1_ff, mag_y1_in;
   logic [DIFF_W-1:0]            diff_x, diff_y;

   logic                         vld2_ff;
   logic [dpbp_pkg::Z_W-1:0]     z2_ff, z2_in;
   logic                         neg_x2_ff, neg_y2_ff;
   logic [MAG_W-1:0]             mag_x2_ff, mag_y2_ff;

   always_comb begin
      vld1_in   = in_valid && (pixel_value < cfg.invalid_threshold);
      d1_in     = dpbp_pkg::PIX_FAR - pixel_value;
      diff_x    = DIFF_W'({pixel_column[CW-1:0], 8'h00}) - DIFF_W'(cfg.center_x);
      diff_y    = DIFF_W'({pixel_row[CW-1:0], 8'h00}) - DIFF_W'(cfg.center_y);
      neg_x1_in = diff_x[DIFF_W-1];
      neg_y1_in = diff_y[DIFF_W-1];
      mag_x1_in = neg_x1_in ? MAG_W'(-diff_x) : MAG_W'(diff_x);
      mag_y1_in = neg_y1_in ? MAG_W'(-diff_y) : MAG_W'(diff_y);
      z2_in     = dpbp_pkg::Z_W'(d1_ff) * dpbp_pkg::Z_W'(cfg.depth_scale);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         vld1_ff <= vld1_in;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      d1_ff     <= d1_in;
      neg_x1_ff <= neg_x1_in;
      neg_y1_ff <= neg_y1_in;
      mag_x1_ff <= mag_x1_in;
      mag_y1_ff <= mag_y1_in;
      z2_ff     <= z2_in;
      neg_x2_ff <= neg_x1_ff;
      neg_y2_ff <= neg_y1_ff;
      mag_x2_ff <= mag_x1_ff;
      mag_y2_ff <= mag_y1_ff;
   end

   assign out_valid = vld2_ff;
   assign out_z     = z2_ff;
   assign out_neg_x = neg_x2_ff;
   assign out_mag_x = mag_x2_ff;
   assign out_neg_y = neg_y2_ff;
   assign out_mag_y = mag_y2_ff;

endmodule

### rtl/dpbp_axis.sv
// ----------------------------------------------------------------------------
// Depth pixel back-projection lateral axis
// Four stages: offset times z, split product by inverse focal length,
// round to Q16.16, then sign and saturate.
// ----------------------------------------------------------------------------
module dpbp_axis #(
   parameter int COORD_BITS = dpbp_pkg::COORD_BITS_DEF,
   localparam int MAG_W = dpbp_pkg::mag_width(COORD_BITS)
) (
   input  logic                                 clock,
   input  logic                                 neg,
   input  logic [MAG_W-1:0]                     mag,
   input  logic [dpbp_pkg::Z_W-1:0]             z,
   input  logic [dpbp_pkg::INV_W-1:0]           inv_focal,
   output logic [dpbp_pkg::POINT_W-1:0]         point
);

   localparam int A_W   = MAG_W + dpbp_pkg::Z_W;
   localparam int HI_W  = A_W - dpbp_pkg::SPLIT_W;
   localparam int PL_W  = dpbp_pkg::SPLIT_W + dpbp_pkg::INV_W;
   localparam int PH_W  = HI_W + dpbp_pkg::INV_W;
   localparam int SUM_W = A_W + dpbp_pkg::INV_W + 1;
   localparam int RM_W  = SUM_W - dpbp_pkg::DROP_W;

   localparam logic [SUM_W-1:0] HALF = SUM_W'(dpbp_pkg::ROUND_HALF);
   localparam logic [RM_W-1:0]  LPOS = RM_W'(dpbp_pkg::LIM_POS);
   localparam logic [RM_W-1:0]  LNEG = RM_W'(dpbp_pkg::LIM_NEG);

   logic [A_W-1:0]               a3_ff, a3_in;
   logic                         neg3_ff, neg4_ff, neg5_ff;
   logic [PH_W-1:0]              ph4_ff, ph4_in;
   logic [PL_W-1:0]              pl4_ff, pl4_in;
   logic [SUM_W-1:0]             sum5;
   logic [RM_W-1:0]              rm5_ff, rm5_in;
   logic [dpbp_pkg::POINT_W-1:0] pt6_ff, pt6_in;

   always_comb begin
      a3_in  = A_W'(mag) * A_W'(z);
      ph4_in = PH_W'(a3_ff[A_W-1:dpbp_pkg::SPLIT_W]) * PH_W'(inv_focal);
      pl4_in = PL_W'(a3_ff[dpbp_pkg::SPLIT_W-1:0]) * PL_W'(inv_focal);
      sum5   = (SUM_W'(ph4_ff) << dpbp_pkg::SPLIT_W) + SUM_W'(pl4_ff) + HALF;
      rm5_in = sum5[SUM_W-1:dpbp_pkg::DROP_W];
      if (neg5_ff) begin
         pt6_in = (rm5_ff > LNEG) ? dpbp_pkg::SAT_NEG
                                  : dpbp_pkg::POINT_W'(-rm5_ff[dpbp_pkg::POINT_W-1:0]);
      end else begin
         pt6_in = (rm5_ff > LPOS) ? dpbp_pkg::SAT_POS : rm5_ff[dpbp_pkg::POINT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      a3_ff   <= a3_in;
      neg3_ff <= neg;
      ph4_ff  <= ph4_in;
      pl4_ff  <= pl4_in;
      neg4_ff <= neg3_ff;
      rm5_ff  <= rm5_in;
      neg5_ff <= neg4_ff;
      pt6_ff  <= pt6_in;
   end

   assign point = pt6_ff;

endmodule

### rtl/depth_pixel_back_projection.sv
// ----------------------------------------------------------------------------
// Depth pixel back-projection
// Turns an inverted depth pixel and its position into a 3-D point with a
// pinhole camera model; pixels at or above the threshold give no point.
//
//   channel   ports                         handshake
//   -------   ---------------------------   ---------------------------------
//   request   req_pixel_value/column/row    start & !busy at a clock edge
//   response  rsp_point_x/y/z               rsp_valid, one cycle, no backpress
//   config    csr_index, csr_wdata          csr_write at a clock edge
//
// One item per clock; busy stays low, so every start is taken.
// A point shows on rsp_valid after its item passes the two front stages and
// four lateral-axis stages (24x24 multipliers, round).
// Reset clears the valid bits in flight and loads the register defaults.
// ----------------------------------------------------------------------------
module depth_pixel_back_projection #(
   parameter int COORD_BITS = dpbp_pkg::COORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [dpbp_pkg::PIX_W-1:0]            req_pixel_value,
   input  logic [dpbp_pkg::COORD_IN_W-1:0]       req_pixel_column,
   input  logic [dpbp_pkg::COORD_IN_W-1:0]       req_pixel_row,
   output logic                                  rsp_valid,
   output logic signed [dpbp_pkg::POINT_W-1:0]   rsp_point_x,
   output logic signed [dpbp_pkg::POINT_W-1:0]   rsp_point_y,
   output logic [dpbp_pkg::POINT_Z_W-1:0]        rsp_point_z,
   input  logic                                  csr_write,
   input  logic [dpbp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [dpbp_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int MAG_W = dpbp_pkg::mag_width(COORD_BITS);
   localparam int BD    = dpbp_pkg::BACK_DEPTH;

   dpbp_pkg::cfg_type             cfg;
   logic                          f_valid;
   logic [dpbp_pkg::Z_W-1:0]      f_z;
   logic                          f_neg_x, f_neg_y;
   logic [MAG_W-1:0]              f_mag_x, f_mag_y;
   logic [dpbp_pkg::POINT_W-1:0]  px, py;

   logic [BD-1:0]                 vld_ff, vld_in;
   logic [dpbp_pkg::Z_W-1:0]      z_ff [BD];
   logic [dpbp_pkg::Z_W-1:0]      z_in [BD];

   assign busy = 1'b0;

   dpbp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dpbp_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .in_valid     (start && !busy),
      .pixel_value  (req_pixel_value),
      .pixel_column (req_pixel_column),
      .pixel_row    (req_pixel_row),
      .out_valid    (f_valid),
      .out_z        (f_z),
      .out_neg_x    (f_neg_x),
      .out_mag_x    (f_mag_x),
      .out_neg_y    (f_neg_y),
      .out_mag_y    (f_mag_y)
   );

   dpbp_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
      .clock     (clock),
      .neg       (f_neg_x),
      .mag       (f_mag_x),
      .z         (f_z),
      .inv_focal (cfg.inv_focal_x),
      .point     (px)
   );

   dpbp_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
      .clock     (clock),
      .neg       (f_neg_y),
      .mag       (f_mag_y),
      .z         (f_z),
      .inv_focal (cfg.inv_focal_y),
      .point     (py)
   );

   always_comb begin
      vld_in  = {vld_ff[BD-2:0], f_valid};
      z_in[0] = f_z;
      for (int i = 1; i < BD; i++) begin
         z_in[i] = z_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < BD; i++) begin
         z_ff[i] <= z_in[i];
      end
   end

   assign rsp_valid   = vld_ff[BD-1];
   assign rsp_point_x = $signed(px);
   assign rsp_point_y = $signed(py);
   assign rsp_point_z = dpbp_pkg::POINT_Z_W'(z_ff[BD-1]);

endmodule

### rtl/dpbp_checker.sv
// ----------------------------------------------------------------------------
// Depth pixel back-projection port checker
// Watches the top-level ports for latency and result consistency.
// ----------------------------------------------------------------------------
`include "depth_pixel_back_projection_defines.svh"

module dpbp_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  busy,
   input  logic [dpbp_pkg::PIX_W-1:0]            req_pixel_value,
   input  logic                                  rsp_valid,
   input  logic signed [dpbp_pkg::POINT_W-1:0]   rsp_point_x,
   input  logic signed [dpbp_pkg::POINT_W-1:0]   rsp_point_y,
   input  logic [dpbp_pkg::POINT_Z_W-1:0]        rsp_point_z
);

   `DPBP_ASSERT_IMP(a_rsp_has_item, rsp_valid, $past(start && !busy, 6), "point without item")

   `DPBP_ASSERT_NXT(a_far_dropped, start && !busy && req_pixel_value == dpbp_pkg::PIX_FAR, ##5 !rsp_valid, "far pixel gave a point")

   `DPBP_ASSERT_IMP(a_zero_depth, rsp_valid && rsp_point_z == '0, rsp_point_x == '0 && rsp_point_y == '0, "nonzero x or y at zero depth")

endmodule

bind depth_pixel_back_projection dpbp_checker u_dpbp_checker (.*);

### sim/depth_pixel_back_projection_tb.sv
// ----------------------------------------------------------------------------
// Depth pixel back-projection testbench
// Streams pixels through the command port under several camera settings,
// predicts each point with an independent fixed-point model of the pinhole
// back-projection and checks every point that comes out, field by field.
// ----------------------------------------------------------------------------
module depth_pixel_back_projection_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dpbp_pkg::*;

   localparam int COORD_BITS     = COORD_BITS_DEF;
   localparam int STALL_MAX      = 13;
   localparam int IDLE_LIMIT     = 2000;
   localparam int SETTLE_CYCLES  = 10;
   localparam int RANDOM_BATCHES = 10;
   localparam int BATCH_PIXELS   = 110;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [PIX_W-1:0]      value;
      logic [COORD_IN_W-1:0] column;
      logic [COORD_IN_W-1:0] row;
      logic [3:0]            gap;
   } pixel_item_type;

   typedef struct packed {
      logic [POINT_W-1:0]   x;
      logic [POINT_W-1:0]   y;
      logic [POINT_Z_W-1:0] z;
   } point_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [PIX_W-1:0]             req_pixel_value = '0;
   logic [COORD_IN_W-1:0]        req_pixel_column = '0;
   logic [COORD_IN_W-1:0]        req_pixel_row = '0;
   logic                         rsp_valid;
   logic signed [POINT_W-1:0]    rsp_point_x;
   logic signed [POINT_W-1:0]    rsp_point_y;
   logic [POINT_Z_W-1:0]         rsp_point_z;
   logic                         csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]         csr_index = '0;
   logic [CSR_DATA_W-1:0]        csr_wdata = '0;

   pixel_item_type pending_pixels[$];
   point_type      expected_points[$];
   cfg_type        cam_cfg = CFG_RESET;
   int             queued_total = 0;
   int             taken_total = 0;
   int             mismatch_count = 0;
   int             idle_cycles = 0;
   bit             taken_q = 1'b0;

   depth_pixel_back_projection #(
      .COORD_BITS (COORD_BITS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_pixel_value  (req_pixel_value),
      .req_pixel_column (req_pixel_column),
      .req_pixel_row    (req_pixel_row),
      .rsp_valid        (rsp_valid),
      .rsp_point_x      (rsp_point_x),
      .rsp_point_y      (rsp_point_y),
      .rsp_point_z      (rsp_point_z),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [POINT_W-1:0] project_axis(
      input logic [COORD_IN_W-1:0] coord,
      input logic [CENTER_W-1:0]   center,
      input logic [Z_W-1:0]        depth,
      input logic [INV_W-1:0]      inv
   );
      logic [COORD_IN_W-1:0] masked;
      longint                offset;
      logic [95:0]           prod;
      logic [63:0]           mag;
      masked = coord & COORD_IN_W'((1 << COORD_BITS) - 1);
      offset = longint'({masked, 8'h00}) - longint'(center);
      prod = 96'(offset < 0 ? -offset : offset) * 96'(depth) * 96'(inv) + 96'(ROUND_HALF);
      mag = prod[95:32];
      if (offset < 0) begin
         return (mag > LIM_NEG) ? SAT_NEG : POINT_W'(64'd0 - mag);
      end
      return (mag > LIM_POS) ? SAT_POS : mag[POINT_W-1:0];
   endfunction

   function automatic bit back_project(input pixel_item_type px, input cfg_type c,
                                       output point_type pt);
      logic [Z_W-1:0] depth;
      pt = '0;
      if (px.value >= c.invalid_threshold) begin
         return 1'b0;
      end
      depth = Z_W'(PIX_FAR - px.value) * Z_W'(c.depth_scale);
      pt.x = project_axis(px.column, c.center_x, depth, c.inv_focal_x);
      pt.y = project_axis(px.row, c.center_y, depth, c.inv_focal_y);
      pt.z = POINT_Z_W'(depth);
      return 1'b1;
   endfunction

   task automatic check_field(input string name, input logic [POINT_W-1:0] want,
                              input logic [POINT_W-1:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // track register writes, accepted pixels and returned points
   always @(posedge clock) begin : track
      pixel_item_type px;
      point_type      pt;
      if (reset) begin
         cam_cfg = CFG_RESET;
         taken_q = 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_CENTER_X:    cam_cfg.center_x = csr_wdata[CENTER_W-1:0];
               CSR_CENTER_Y:    cam_cfg.center_y = csr_wdata[CENTER_W-1:0];
               CSR_INV_FOCAL_X: cam_cfg.inv_focal_x = csr_wdata[INV_W-1:0];
               CSR_INV_FOCAL_Y: cam_cfg.inv_focal_y = csr_wdata[INV_W-1:0];
               CSR_DEPTH_SCALE: cam_cfg.depth_scale = csr_wdata[SCALE_W-1:0];
               CSR_INVALID_THR: cam_cfg.invalid_threshold = csr_wdata[THRESH_W-1:0];
               default: ;
            endcase
         end
         taken_q = start && !busy;
         if (taken_q) begin
            px.value = req_pixel_value;
            px.column = req_pixel_column;
            px.row = req_pixel_row;
            px.gap = '0;
            taken_total++;
            if (back_project(px, cam_cfg, pt)) begin
               expected_points = {expected_points, pt};
            end
         end
         if (rsp_valid) begin
            if (expected_points.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected point, expected none, actual %h %h %h",
                        $time, rsp_point_x, rsp_point_y, rsp_point_z);
            end else begin
               pt = expected_points.pop_front();
               check_field("point_x", pt.x, rsp_point_x);
               check_field("point_y", pt.y, rsp_point_y);
               check_field("point_z", POINT_W'(pt.z), POINT_W'(rsp_point_z));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("** depth_pixel_back_projection: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // hold until taken, then idle out the gap of the next item and present it
   always @(negedge clock) begin : drive
      pixel_item_type px;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || taken_q) begin
         if (pending_pixels.size() == 0) begin
            start <= 1'b0;
         end else if (pending_pixels[0].gap != 0) begin
            pending_pixels[0].gap = pending_pixels[0].gap - 4'd1;
            start <= 1'b0;
         end else begin
            px = pending_pixels.pop_front();
            req_pixel_value <= px.value;
            req_pixel_column <= px.column;
            req_pixel_row <= px.row;
            start <= 1'b1;
         end
      end
   end

   task automatic queue_pixel(input logic [PIX_W-1:0] value,
                              input logic [COORD_IN_W-1:0] column,
                              input logic [COORD_IN_W-1:0] row, input int gap);
      pixel_item_type px;
      px.value = value;
      px.column = column;
      px.row = row;
      px.gap = 4'(gap);
      pending_pixels = {pending_pixels, px};
      queued_total++;
   endtask

   task automatic drain_and_settle();
      while (taken_total != queued_total || expected_points.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // unused upper data bits carry random junk
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value, input int bits);
      logic [CSR_DATA_W-1:0] data;
      logic [CSR_DATA_W-1:0] mask;
      mask = (CSR_DATA_W'(1) << bits) - CSR_DATA_W'(1);
      data = (CSR_DATA_W'($urandom) & ~mask) | (value & mask);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   task automatic program_camera(input cfg_type c);
      write_csr(CSR_CENTER_X, CSR_DATA_W'(c.center_x), CENTER_W);
      write_csr(CSR_CENTER_Y, CSR_DATA_W'(c.center_y), CENTER_W);
      write_csr(CSR_INV_FOCAL_X, CSR_DATA_W'(c.inv_focal_x), INV_W);
      write_csr(CSR_INV_FOCAL_Y, CSR_DATA_W'(c.inv_focal_y), INV_W);
      write_csr(CSR_DEPTH_SCALE, CSR_DATA_W'(c.depth_scale), SCALE_W);
      write_csr(CSR_INVALID_THR, CSR_DATA_W'(c.invalid_threshold), THRESH_W);
      write_csr(($urandom_range(0, 1) != 0) ? CSR_SPARE_HI : CSR_SPARE_LO, '0, 0);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic cfg_type random_camera(input bit wide);
      cfg_type c;
      if (wide) begin
         c.center_x = CENTER_W'($urandom);
         c.center_y = CENTER_W'($urandom);
         c.inv_focal_x = INV_W'($urandom);
         c.inv_focal_y = INV_W'($urandom);
      end else begin
         c.center_x = CENTER_W'($urandom_range(0, 4095 * 256));
         c.center_y = CENTER_W'($urandom_range(0, 4095 * 256));
         c.inv_focal_x = INV_W'($urandom_range(1, 65535));
         c.inv_focal_y = INV_W'($urandom_range(1, 65535));
      end
      c.depth_scale = SCALE_W'($urandom);
      case ($urandom_range(0, 7))
         0:       c.invalid_threshold = 8'd255;
         1:       c.invalid_threshold = THRESH_W'($urandom);
         default: c.invalid_threshold = THRESH_W'($urandom_range(200, 255));
      endcase
      return c;
   endfunction

   initial begin : stimulus
      cfg_type c;
      int      gap;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_pixel(8'd0, 12'd0, 12'd0, 0);
      queue_pixel(8'd0, 12'd4095, 12'd4095, 0);
      queue_pixel(8'd255, 12'd100, 12'd100, 0);
      queue_pixel(8'd254, 12'd100, 12'd100, 0);
      queue_pixel(8'd253, 12'd325, 12'd238, 0);
      queue_pixel(8'd128, 12'd326, 12'd239, 3);
      queue_pixel(8'd1, 12'd2048, 12'd1024, 0);
      drain_and_settle();

      // positive saturation
      c = '{center_x: '0, center_y: '0, inv_focal_x: '1, inv_focal_y: '1,
            depth_scale: '1, invalid_threshold: 8'd255};
      program_camera(c);
      queue_pixel(8'd0, 12'd4095, 12'd4095, 0);
      queue_pixel(8'd254, 12'd0, 12'd0, 0);
      queue_pixel(8'd254, 12'd1, 12'd1, 2);
      queue_pixel(8'd255, 12'd4095, 12'd4095, 0);
      drain_and_settle();

      // negative saturation
      c.center_x = '1;
      c.center_y = '1;
      program_camera(c);
      queue_pixel(8'd0, 12'd0, 12'd0, 0);
      queue_pixel(8'd0, 12'd4095, 12'd4095, 0);
      queue_pixel(8'd254, 12'd4095, 12'd0, 0);
      drain_and_settle();

      // zero inverse focal length, then zero scale
      c = '{center_x: CENTER_W'($urandom), center_y: CENTER_W'($urandom),
            inv_focal_x: '0, inv_focal_y: 24'd1, depth_scale: '1,
            invalid_threshold: 8'd128};
      program_camera(c);
      queue_pixel(8'd0, 12'd4095, 12'd0, 0);
      queue_pixel(8'd127, 12'd0, 12'd4095, 1);
      queue_pixel(8'd128, 12'd5, 12'd5, 0);
      drain_and_settle();
      c.inv_focal_x = '1;
      c.inv_focal_y = '1;
      c.depth_scale = '0;
      c.invalid_threshold = 8'd255;
      program_camera(c);
      queue_pixel(8'd0, 12'd4095, 12'd4095, 0);
      queue_pixel(8'd100, 12'd0, 12'd0, 0);
      drain_and_settle();

      // threshold of zero drops every pixel
      c.depth_scale = '1;
      c.invalid_threshold = '0;
      program_camera(c);
      queue_pixel(8'd0, 12'd0, 12'd0, 0);
      queue_pixel(8'd0, 12'd4095, 12'd4095, 0);
      queue_pixel(8'd255, 12'd2048, 12'd2048, 0);
      drain_and_settle();

      for (int b = 0; b < RANDOM_BATCHES; b++) begin
         program_camera(random_camera(b % 2 == 1));
         for (int n = 0; n < BATCH_PIXELS; n++) begin
            case (b % 3)
               0:       gap = 0;
               1:       gap = $urandom_range(0, STALL_MAX);
               default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, STALL_MAX) : 0;
            endcase
            queue_pixel(PIX_W'($urandom), COORD_IN_W'($urandom), COORD_IN_W'($urandom), gap);
         end
         drain_and_settle();
      end

      if (mismatch_count == 0) begin
         $display("** depth_pixel_back_projection: PASSED **");
      end else begin
         $display("** depth_pixel_back_projection: FAILED **");
      end
      $finish;
   end

endmodule

### depth_pixel_back_projection.f
+incdir+rtl
rtl/dpbp_pkg.sv
rtl/dpbp_csr.sv
rtl/dpbp_front.sv
rtl/dpbp_axis.sv
rtl/depth_pixel_back_projection.sv
rtl/dpbp_checker.sv
sim/depth_pixel_back_projection_tb.sv
